// ===== rtl/ffpd_pkg.sv =====
// ffpd_pkg: payload types and character constants for the form field percent decoder.
// Standalone package; used by form_field_percent_decoder.
package ffpd_pkg;

    typedef struct packed {
        logic [7:0] src_byte;
        logic       field_start;
    } t_in_item;

    typedef struct packed {
        logic        char_valid;
        logic [7:0]  out_char;
        logic        field_end;
        logic        found_text;
        logic [13:0] consumed;
        logic        terminated;
    } t_out_item;

    localparam logic [7:0]  CH_PERCENT = 8'h25;
    localparam logic [7:0]  CH_PLUS    = 8'h2B;
    localparam logic [7:0]  CH_SPACE   = 8'h20;
    localparam logic [7:0]  CH_DOT     = 8'h2E;
    localparam logic [7:0]  CH_UNDER   = 8'h5F;
    localparam logic [7:0]  CH_DASH    = 8'h2D;
    localparam logic [7:0]  CH_STAR    = 8'h2A;
    localparam logic [7:0]  CH_NUL     = 8'h00;

    localparam logic [13:0] USED_MAX        = 14'h3FFF;
    localparam logic [11:0] MAX_CHARS_RESET = 12'd64;

endpackage

// ===== rtl/form_field_percent_decoder.sv =====
// form_field_percent_decoder: top level, byte-wide form field decoder with percent escapes.
// Depends on ffpd_pkg for payload types and character constants.
// A result appears in the output register the cycle after its input transfer.
// Throughput: one input byte per cycle; the field state and the result register both
//   update on the same edge, so the only stall is a full result register held by the sink.
// Reset (synchronous, active low): decoder idle, counters cleared, max_chars back to 64,
//   result register empty.
module form_field_percent_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration: max_chars
    input  logic                 i_cfg_wen,
    input  logic [11:0]          i_cfg_wdata,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ffpd_pkg::t_in_item   i_in_data,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ffpd_pkg::t_out_item  o_out_data
);

    // Field phase codes; unused codes behave as idle.
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_RUN  = 3'd1;
    localparam logic [2:0] PH_ESC1 = 3'd2;
    localparam logic [2:0] PH_ESC2 = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    logic [11:0]         r_max_chars;
    logic [2:0]          r_phase,  n_phase;
    logic [3:0]          r_esc_hi, n_esc_hi;
    logic [11:0]         r_room,   n_room;
    logic [13:0]         r_used,   n_used;

    logic                r_out_valid;
    ffpd_pkg::t_out_item r_out_data;

    logic                n_have_res;
    ffpd_pkg::t_out_item n_res;
    logic                in_xfer;

    // Hex digit value, 16 flags a non-hex byte.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        begin
            v = 5'd16;
            if (b >= 8'h30 && b <= 8'h39) begin
                v = 5'(b - 8'h30);
            end else if (b >= 8'h41 && b <= 8'h46) begin
                v = 5'(b - 8'h37);
            end else if (b >= 8'h61 && b <= 8'h66) begin
                v = 5'(b - 8'h57);
            end
            return v;
        end
    endfunction

    // Escapes allowed: 2x, 3A-3F, 40, 5B-5F, 60, 7B-7E.
    function automatic logic escape_ok(input logic [3:0] hi, input logic [4:0] lo);
        logic ok;
        begin
            ok = 1'b0;
            if (!lo[4]) begin
                case (hi)
                    4'd2:    ok = 1'b1;
                    4'd3:    ok = (lo >= 5'd10);
                    4'd4:    ok = (lo == 5'd0);
                    4'd5:    ok = (lo >= 5'd11);
                    4'd6:    ok = (lo == 5'd0);
                    4'd7:    ok = (lo >= 5'd11) && (lo <= 5'd14);
                    default: ok = 1'b0;
                endcase
            end
            return ok;
        end
    endfunction

    // Accept whenever the result register is free or being drained this cycle.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Single-pass decode of one byte against the field state.
    always_comb begin
        logic [7:0]  b;
        logic [2:0]  cur_phase;
        logic [11:0] cur_room;
        logic [13:0] cur_used;
        logic        do_emit;
        logic        do_stop;
        logic [7:0]  emit_c;
        logic [1:0]  emit_n;
        logic [14:0] sum;
        logic [11:0] room_dec;
        logic [4:0]  lo;

        b         = i_in_data.src_byte;
        cur_phase = r_phase;
        cur_room  = r_room;
        cur_used  = r_used;
        do_emit   = 1'b0;
        do_stop   = 1'b0;
        emit_c    = ffpd_pkg::CH_NUL;
        emit_n    = 2'd1;
        sum       = '0;
        room_dec  = '0;
        lo        = hex_value(b);

        n_phase    = r_phase;
        n_esc_hi   = r_esc_hi;
        n_room     = r_room;
        n_used     = r_used;
        n_have_res = 1'b0;
        n_res      = '0;

        if (i_in_data.field_start) begin
            // Restart: drop whatever field was open.
            cur_room  = r_max_chars;
            cur_used  = '0;
            cur_phase = PH_RUN;
            n_room    = r_max_chars;
            n_used    = '0;
            n_esc_hi  = '0;
            n_phase   = PH_RUN;
        end

        if (i_in_data.field_start && b == ffpd_pkg::CH_NUL) begin
            // Empty field: end at once, no text.
            n_have_res       = 1'b1;
            n_res.field_end  = 1'b1;
            n_phase          = PH_DONE;
        end else if (i_in_data.field_start && r_max_chars == '0) begin
            // No capacity: end with text seen, byte not counted.
            n_have_res       = 1'b1;
            n_res.field_end  = 1'b1;
            n_res.found_text = 1'b1;
            n_phase          = PH_DONE;
        end else begin
            case (cur_phase)
                PH_RUN: begin
                    if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
                        (b >= 8'h61 && b <= 8'h7A) || b == ffpd_pkg::CH_DOT ||
                        b == ffpd_pkg::CH_UNDER || b == ffpd_pkg::CH_DASH ||
                        b == ffpd_pkg::CH_STAR) begin
                        do_emit = 1'b1;
                        emit_c  = b;
                    end else if (b == ffpd_pkg::CH_PLUS) begin
                        do_emit = 1'b1;
                        emit_c  = ffpd_pkg::CH_SPACE;
                    end else if (b == ffpd_pkg::CH_PERCENT) begin
                        n_phase = PH_ESC1;
                    end else begin
                        do_stop = 1'b1;
                    end
                end
                PH_ESC1: begin
                    if (b >= 8'h32 && b <= 8'h37) begin
                        n_esc_hi = b[3:0];
                        n_phase  = PH_ESC2;
                    end else begin
                        do_stop = 1'b1;
                    end
                end
                PH_ESC2: begin
                    if (escape_ok(r_esc_hi, lo)) begin
                        do_emit = 1'b1;
                        emit_c  = {r_esc_hi, lo[3:0]};
                        emit_n  = 2'd3;
                    end else begin
                        do_stop = 1'b1;
                    end
                end
                default: begin
                    // idle or done: ignore stray bytes
                end
            endcase

            if (do_emit) begin
                sum      = {1'b0, cur_used} + {13'd0, emit_n};
                n_used   = sum[14] ? ffpd_pkg::USED_MAX : sum[13:0];
                room_dec = (cur_room != '0) ? cur_room - 12'd1 : cur_room;
                n_room   = room_dec;
                n_phase  = PH_RUN;
                n_have_res       = 1'b1;
                n_res.char_valid = 1'b1;
                n_res.out_char   = emit_c;
                if (room_dec == '0) begin
                    // Capacity reached on this character: close the field, no room left.
                    n_res.field_end  = 1'b1;
                    n_res.found_text = 1'b1;
                    n_res.consumed   = n_used;
                    n_phase          = PH_DONE;
                end
            end else if (do_stop) begin
                // Stopping byte and any partial escape are not counted.
                n_have_res       = 1'b1;
                n_res.field_end  = 1'b1;
                n_res.found_text = 1'b1;
                n_res.consumed   = cur_used;
                n_res.terminated = (cur_room != '0);
                n_phase          = PH_DONE;
            end
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chars <= ffpd_pkg::MAX_CHARS_RESET;
        end else if (i_cfg_wen) begin
            r_max_chars <= i_cfg_wdata;
        end
    end

    // Field state: advance on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_esc_hi <= '0;
            r_room   <= '0;
            r_used   <= '0;
        end else if (in_xfer) begin
            r_phase  <= n_phase;
            r_esc_hi <= n_esc_hi;
            r_room   <= n_room;
            r_used   <= n_used;
        end
    end

    // Result register: load on a transfer that yields a result, drop when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer && n_have_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && n_have_res) begin
            r_out_data <= n_res;
        end
    end

    // An open field always has room for at least one more character.
    a_room_while_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RUN || r_phase == PH_ESC1 || r_phase == PH_ESC2) |-> (r_room != '0))
        else $error("open field with no room left");

    // A result that does not close the field must carry a character and no summary.
    a_mid_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data.field_end) |->
            (r_out_data.char_valid && !r_out_data.found_text &&
             !r_out_data.terminated && r_out_data.consumed == '0))
        else $error("mid-field result malformed");

    // A field that starts on the terminator closes at once as empty.
    a_empty_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_data.field_start && i_in_data.src_byte == ffpd_pkg::CH_NUL) |=>
            (r_out_valid && r_out_data.field_end && !r_out_data.found_text &&
             !r_out_data.char_valid && r_phase == PH_DONE))
        else $error("empty field not reported");

endmodule
